### rtl/jacobi_linear_solver_top_macros.svh
// assertion helpers for the rtl, included by jls_back
`ifndef JACOBI_LINEAR_SOLVER_TOP_MACROS_SVH
`define JACOBI_LINEAR_SOLVER_TOP_MACROS_SVH

// same-cycle implication
`define JLS_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("jls assertion failed");

// next-cycle implication
`define JLS_ASSERT_NXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("jls assertion failed");

`endif

### rtl/jls_pkg.sv
`timescale 1ns / 1ps
package jls_pkg;
   localparam int MAX_UNKNOWNS  = 16;
   localparam int FRACTION_BITS = 16;
   localparam int DATA_W        = 32;
   localparam int IDX_W         = $clog2(MAX_UNKNOWNS);
   localparam int CNT_W         = $clog2(MAX_UNKNOWNS + 1);
   localparam int STORE_DEPTH   = MAX_UNKNOWNS * (MAX_UNKNOWNS + 1);
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int ACC_W         = 2 * DATA_W + CNT_W;
   localparam int DIV_CNT_W     = $clog2(ACC_W);
   localparam int SUM_W         = DATA_W + IDX_W;
   localparam int TOL_W         = 16;
   localparam int LIMIT_W       = 16;
   localparam int STATUS_W      = 2;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
   localparam int RSP_DATA_W    = 56;

   localparam logic [CSR_ADDR_W-1:0] CSR_UNKNOWNS  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TOLERANCE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIMIT     = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_CONVERGED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_DOM   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_DIAG = 2'd3;

   typedef struct packed {
      logic [CNT_W-1:0]   n;
      logic [TOL_W-1:0]   tol;
      logic [LIMIT_W-1:0] limit;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] coef;
      logic              last;
   } qent_type;
endpackage

### rtl/jacobi_linear_solver_top.sv
// loading: one word per cycle into the store while the fifo has room, n*(n+1) words per system
// dominance and zero-diagonal check: one store read at a time, a read state then a use state per word
// each sweep: per coefficient a read, multiply and accumulate step, then per row a bit-serial divide
// results: after the solve, one word per cycle while rsp_tready is high, n words or one error word
// reset: synchronous, active high; clears control and csr registers, not data or the matrix store
`timescale 1ns / 1ps
module jacobi_linear_solver_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [jls_pkg::DATA_W-1:0]         req_tdata,   // coefficient
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status, sweeps_done, unknown_index, solution_value, zero pad
   output logic [jls_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [jls_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [jls_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import jls_pkg::*;

   cfg_type  cfg;
   qent_type fifo_wdata, fifo_rdata;
   logic     fifo_push, fifo_pop, fifo_full, fifo_empty;

   jls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fifo_full  (fifo_full),
      .fifo_push  (fifo_push),
      .fifo_wdata (fifo_wdata),
      .cfg        (cfg)
   );

   jls_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (fifo_push),
      .wdata (fifo_wdata),
      .pop   (fifo_pop),
      .rdata (fifo_rdata),
      .full  (fifo_full),
      .empty (fifo_empty)
   );

   jls_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .fifo_empty (fifo_empty),
      .fifo_rdata (fifo_rdata),
      .fifo_pop   (fifo_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

### rtl/jls_front.sv
`timescale 1ns / 1ps
module jls_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [jls_pkg::DATA_W-1:0]         req_tdata,
   input  logic                               csr_we,
   input  logic [jls_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [jls_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               fifo_full,
   output logic                               fifo_push,
   output jls_pkg::qent_type                  fifo_wdata,
   output jls_pkg::cfg_type                   cfg
);
   import jls_pkg::*;

   logic [CNT_W-1:0]   n_raw_ff, n_raw_in;
   logic [TOL_W-1:0]   tol_ff, tol_in;
   logic [LIMIT_W-1:0] lim_ff, lim_in;
   logic [ADDR_W-1:0]  load_ff, load_in;
   logic [CNT_W-1:0]   n_eff;
   logic [ADDR_W-1:0]  total;
   logic               is_last;

   always_comb begin
      if (n_raw_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (n_raw_ff > CNT_W'(MAX_UNKNOWNS)) begin
         n_eff = CNT_W'(MAX_UNKNOWNS);
      end else begin
         n_eff = n_raw_ff;
      end
   end

   assign total      = ADDR_W'(ADDR_W'(n_eff) * (ADDR_W'(n_eff) + ADDR_W'(1)));
   assign is_last    = (load_ff == total - ADDR_W'(1));
   assign req_tready = !fifo_full;
   assign fifo_push  = req_tvalid && req_tready;
   assign fifo_wdata = '{addr: load_ff, coef: req_tdata, last: is_last};
   assign cfg.n      = n_eff;
   assign cfg.tol    = tol_ff;
   assign cfg.limit  = (lim_ff == '0) ? LIMIT_W'(1) : lim_ff;

   always_comb begin
      n_raw_in = n_raw_ff;
      tol_in   = tol_ff;
      lim_in   = lim_ff;
      load_in  = load_ff;
      if (fifo_push) begin
         load_in = is_last ? '0 : load_ff + ADDR_W'(1);
      end
      if (csr_we) begin
         case (csr_addr)
            CSR_UNKNOWNS: begin
               n_raw_in = csr_wdata[CNT_W-1:0];
               load_in  = '0;
            end
            CSR_TOLERANCE: tol_in = csr_wdata[TOL_W-1:0];
            CSR_LIMIT:     lim_in = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_raw_ff <= CNT_W'(4);
         tol_ff   <= TOL_W'(1);
         lim_ff   <= LIMIT_W'(1000);
         load_ff  <= '0;
      end else begin
         n_raw_ff <= n_raw_in;
         tol_ff   <= tol_in;
         lim_ff   <= lim_in;
         load_ff  <= load_in;
      end
   end
endmodule

### rtl/jls_fifo.sv
`timescale 1ns / 1ps
module jls_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jls_pkg::qent_type wdata,
   input  logic              pop,
   output jls_pkg::qent_type rdata,
   output logic              full,
   output logic              empty
);
   import jls_pkg::*;

   qent_type                slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_PTR_W:0]     cnt_ff, cnt_in;

   assign full  = (cnt_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign empty = (cnt_ff == '0);
   assign rdata = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + FIFO_PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + FIFO_PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

### rtl/jls_div.sv
`timescale 1ns / 1ps
module jls_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [jls_pkg::ACC_W-1:0]  dividend,
   input  logic signed [jls_pkg::DATA_W-1:0] divisor,
   output logic                              done,
   output logic signed [jls_pkg::DATA_W-1:0] quotient
);
   import jls_pkg::*;

   logic [ACC_W-1:0]     mag_ff, mag_in;
   logic [DATA_W:0]      rem_ff, rem_in;
   logic [DATA_W-1:0]    den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DATA_W:0]      rem_sh;
   logic                 ge;
   logic                 big;

   assign rem_sh = {rem_ff[DATA_W-1:0], mag_ff[ACC_W-1]};
   assign ge     = (rem_sh >= {1'b0, den_ff});
   assign big    = |mag_ff[ACC_W-1:DATA_W];
   assign done   = done_ff;

   always_comb begin
      if (neg_ff) begin
         if (big || mag_ff[DATA_W-1:0] > {1'b1, {(DATA_W-1){1'b0}}}) begin
            quotient = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            quotient = -$signed(mag_ff[DATA_W-1:0]);
         end
      end else begin
         if (big || mag_ff[DATA_W-1]) begin
            quotient = {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            quotient = $signed(mag_ff[DATA_W-1:0]);
         end
      end
   end

   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         mag_in  = dividend[ACC_W-1] ? ACC_W'(-dividend) : dividend;
         den_in  = divisor[DATA_W-1] ? DATA_W'(-divisor) : divisor;
         neg_in  = dividend[ACC_W-1] ^ divisor[DATA_W-1];
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         mag_in = {mag_ff[ACC_W-2:0], ge};
         rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(ACC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule

### rtl/jls_back.sv
`timescale 1ns / 1ps
module jls_back (
   input  logic                              clock,
   input  logic                              reset,
   input  jls_pkg::cfg_type                  cfg,
   input  logic                              fifo_empty,
   input  jls_pkg::qent_type                 fifo_rdata,
   output logic                              fifo_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [jls_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast
);
   import jls_pkg::*;
   `include "jacobi_linear_solver_top_macros.svh"

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b00000000001,
      ST_DOM_RD   = 11'b00000000010,
      ST_DOM_USE  = 11'b00000000100,
      ST_DOM_END  = 11'b00000001000,
      ST_SW_RD    = 11'b00000010000,
      ST_SW_MUL   = 11'b00000100000,
      ST_SW_ACC   = 11'b00001000000,
      ST_SW_DGO   = 11'b00010000000,
      ST_SW_DWAIT = 11'b00100000000,
      ST_CONV     = 11'b01000000000,
      ST_EMIT     = 11'b10000000000
   } state_type;

   state_type                  state_ff, state_in;
   logic signed [DATA_W-1:0]   store_mem [STORE_DEPTH];
   logic signed [DATA_W-1:0]   rd_data_ff;
   logic signed [DATA_W-1:0]   prev_ff [MAX_UNKNOWNS];
   logic signed [DATA_W-1:0]   next_ff [MAX_UNKNOWNS];
   logic signed [2*DATA_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [DATA_W-1:0]   diag_ff, diag_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;
   logic [IDX_W-1:0]           i_ff, i_in;
   logic [CNT_W-1:0]           j_ff, j_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [DATA_W-1:0]          dmag_ff, dmag_in;
   logic                       fail_ff, fail_in;
   logic                       zero_ff, zero_in;
   logic                       nd_ff, nd_in;
   logic [LIMIT_W-1:0]         sweep_ff, sweep_in;
   logic [STATUS_W-1:0]        code_ff, code_in;
   logic                       err_ff, err_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       prev_clear, prev_copy, next_write;
   logic                       div_start, div_done;
   logic signed [DATA_W-1:0]   div_q;
   logic [IDX_W-1:0]           jx;
   logic [DATA_W-1:0]          d_mag;
   logic signed [DATA_W:0]     diff;
   logic [DATA_W:0]            diff_mag;
   logic                       j_end, i_end, on_diag;
   logic [CNT_W-1:0]           emit_cnt;
   logic                       emit_load;

   jls_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (diag_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign jx        = j_ff[IDX_W-1:0];
   assign j_end     = (j_ff == cfg.n);
   assign i_end     = ({1'b0, i_ff} == cfg.n - CNT_W'(1));
   assign on_diag   = (j_ff == {1'b0, i_ff});
   assign d_mag     = rd_data_ff[DATA_W-1] ? DATA_W'(-rd_data_ff) : rd_data_ff;
   assign diff      = (DATA_W+1)'(prev_ff[jx]) - (DATA_W+1)'(next_ff[jx]);
   assign diff_mag  = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;
   assign emit_cnt  = err_ff ? CNT_W'(1) : cfg.n;
   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign fifo_pop  = (state_ff == ST_IDLE) && !fifo_empty;
   assign div_start = (state_ff == ST_SW_DGO);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      diag_in      = diag_ff;
      addr_in      = addr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      sum_in       = sum_ff;
      dmag_in      = dmag_ff;
      fail_in      = fail_ff;
      zero_in      = zero_ff;
      nd_in        = nd_ff;
      sweep_in     = sweep_ff;
      code_in      = code_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      prev_clear   = 1'b0;
      prev_copy    = 1'b0;
      next_write   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (fifo_pop && fifo_rdata.last) begin
               addr_in  = '0;
               i_in     = '0;
               j_in     = '0;
               sum_in   = '0;
               fail_in  = 1'b0;
               zero_in  = 1'b0;
               state_in = ST_DOM_RD;
            end
         end
         ST_DOM_RD: state_in = ST_DOM_USE;
         ST_DOM_USE: begin
            if (j_end) begin
               fail_in = fail_ff || (SUM_W'(dmag_ff) < sum_ff);
               sum_in  = '0;
            end else if (on_diag) begin
               dmag_in = d_mag;
               zero_in = zero_ff || (rd_data_ff == '0);
            end else begin
               sum_in = sum_ff + SUM_W'(d_mag);
            end
            addr_in = addr_ff + ADDR_W'(1);
            if (j_end) begin
               j_in     = '0;
               i_in     = i_ff + IDX_W'(1);
               state_in = i_end ? ST_DOM_END : ST_DOM_RD;
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_DOM_RD;
            end
         end
         ST_DOM_END: begin
            if (fail_ff || zero_ff) begin
               err_in   = 1'b1;
               code_in  = fail_ff ? STATUS_NOT_DOM : STATUS_ZERO_DIAG;
               j_in     = '0;
               state_in = ST_EMIT;
            end else begin
               err_in     = 1'b0;
               prev_clear = 1'b1;
               sweep_in   = LIMIT_W'(1);
               addr_in    = '0;
               i_in       = '0;
               j_in       = '0;
               acc_in     = '0;
               nd_in      = 1'b0;
               state_in   = ST_SW_RD;
            end
         end
         ST_SW_RD: state_in = ST_SW_MUL;
         ST_SW_MUL: begin
            if (on_diag) begin
               diag_in = rd_data_ff;
            end
            state_in = ST_SW_ACC;
         end
         ST_SW_ACC: begin
            if (j_end) begin
               acc_in   = acc_ff + (ACC_W'(rd_data_ff) <<< FRACTION_BITS);
               state_in = ST_SW_DGO;
            end else begin
               if (!on_diag) begin
                  acc_in = acc_ff - ACC_W'(prod_ff);
               end
               addr_in  = addr_ff + ADDR_W'(1);
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_SW_RD;
            end
         end
         ST_SW_DGO: state_in = ST_SW_DWAIT;
         ST_SW_DWAIT: begin
            if (div_done) begin
               next_write = 1'b1;
               acc_in     = '0;
               addr_in    = addr_ff + ADDR_W'(1);
               j_in       = '0;
               if (i_end) begin
                  state_in = ST_CONV;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_SW_RD;
               end
            end
         end
         ST_CONV: begin
            prev_copy = 1'b1;
            nd_in     = nd_ff || (diff_mag > (DATA_W+1)'(cfg.tol));
            j_in      = j_ff + CNT_W'(1);
            if (j_ff == cfg.n - CNT_W'(1)) begin
               j_in = '0;
               if (!nd_in) begin
                  code_in  = STATUS_CONVERGED;
                  state_in = ST_EMIT;
               end else if (sweep_ff >= cfg.limit) begin
                  code_in  = STATUS_LIMIT;
                  state_in = ST_EMIT;
               end else begin
                  sweep_in = sweep_ff + LIMIT_W'(1);
                  addr_in  = '0;
                  i_in     = '0;
                  acc_in   = '0;
                  nd_in    = 1'b0;
                  state_in = ST_SW_RD;
               end
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (j_ff == emit_cnt - CNT_W'(1));
               if (err_ff) begin
                  rsp_data_in = {{(RSP_DATA_W-STATUS_W){1'b0}}, code_ff};
               end else begin
                  rsp_data_in = RSP_DATA_W'({next_ff[jx], jx, sweep_ff, code_ff});
               end
               j_in = j_ff + CNT_W'(1);
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fifo_pop) begin
         store_mem[fifo_rdata.addr] <= fifo_rdata.coef;
      end
      rd_data_ff <= store_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prev_ff[jx] * rd_data_ff;
      if (next_write) begin
         next_ff[i_ff] <= div_q;
      end
      for (int k = 0; k < MAX_UNKNOWNS; k++) begin
         if (prev_clear) begin
            prev_ff[k] <= '0;
         end
      end
      if (prev_copy) begin
         prev_ff[jx] <= next_ff[jx];
      end
      acc_ff      <= acc_in;
      diag_ff     <= diag_in;
      addr_ff     <= addr_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      sum_ff      <= sum_in;
      dmag_ff     <= dmag_in;
      fail_ff     <= fail_in;
      zero_ff     <= zero_in;
      nd_ff       <= nd_in;
      sweep_ff    <= sweep_in;
      code_ff     <= code_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `JLS_ASSERT_IMP(a_div_quiet, state_ff != ST_SW_DWAIT, !div_done)
   `JLS_ASSERT_NXT(a_div_go_busy, state_ff == ST_SW_DGO, !div_done)
   `JLS_ASSERT_IMP(a_emit_range, state_ff == ST_EMIT, j_ff < emit_cnt)
   `JLS_ASSERT_IMP(a_sweep_range, state_ff == ST_SW_RD || state_ff == ST_CONV, sweep_ff != '0 && sweep_ff <= cfg.limit)
endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import jls_pkg::*;

   localparam int  LIMIT_CYCLES = 5000000;
   localparam int  DRAIN_CYCLES = 200;
   localparam longint SAT_MAX   = 64'sh7FFFFFFF;
   localparam longint SAT_MIN   = -64'sh80000000;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] sweeps;
      logic [3:0]  index;
      logic [31:0] value;
      logic        last;
   } soln_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   jacobi_linear_solver_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // solver mirror
   logic signed [31:0] coef_mem [STORE_DEPTH];
   logic [4:0]         mirror_unknowns = 5'd4;
   logic [15:0]        mirror_tol = 16'd1;
   logic [15:0]        mirror_limit = 16'd1000;
   int                 load_pos = 0;
   soln_word_type      pending_solns [$];

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int words_sent = 0;
   int systems_solved = 0;
   int results_seen = 0;

   function automatic int eff_unknowns();
      if (mirror_unknowns == 0) return 1;
      if (mirror_unknowns > MAX_UNKNOWNS) return MAX_UNKNOWNS;
      return mirror_unknowns;
   endfunction

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic void push_error_word(logic [1:0] code);
      soln_word_type w;
      w = '{status: code, sweeps: '0, index: '0, value: '0, last: 1'b1};
      pending_solns.push_back(w);
   endfunction

   function automatic void solve_system();
      int n, w, lim, sweeps;
      longint sum, diff;
      longint prev_x [MAX_UNKNOWNS];
      longint next_x [MAX_UNKNOWNS];
      logic signed [95:0] acc, dd, q;
      logic [1:0] code;
      bit done, zero_diag;
      soln_word_type r;
      n = eff_unknowns();
      w = n + 1;
      systems_solved++;
      for (int i = 0; i < n; i++) begin
         sum = 0;
         for (int j = 0; j < n; j++)
            if (j != i) sum += mag(longint'(coef_mem[i*w+j]));
         if (mag(longint'(coef_mem[i*w+i])) < sum) begin
            push_error_word(STATUS_NOT_DOM);
            return;
         end
      end
      zero_diag = 0;
      for (int i = 0; i < n; i++)
         if (coef_mem[i*w+i] == 0) zero_diag = 1;
      if (zero_diag) begin
         push_error_word(STATUS_ZERO_DIAG);
         return;
      end
      for (int i = 0; i < MAX_UNKNOWNS; i++) begin
         prev_x[i] = 0;
         next_x[i] = 0;
      end
      lim = (mirror_limit == 0) ? 1 : mirror_limit;
      sweeps = 0;
      forever begin
         sweeps++;
         for (int i = 0; i < n; i++) begin
            acc = longint'(coef_mem[i*w+n]) * 64'sd65536;
            for (int j = 0; j < n; j++)
               if (j != i) acc = acc - (prev_x[j] * longint'(coef_mem[i*w+j]));
            dd = longint'(coef_mem[i*w+i]);
            q = acc / dd;
            if (q > SAT_MAX) next_x[i] = SAT_MAX;
            else if (q < SAT_MIN) next_x[i] = SAT_MIN;
            else next_x[i] = longint'(q[63:0]);
         end
         done = 1;
         for (int i = 0; i < n; i++) begin
            diff = prev_x[i] - next_x[i];
            if (mag(diff) > longint'(mirror_tol)) done = 0;
         end
         if (done) begin
            code = STATUS_CONVERGED;
            break;
         end
         prev_x = next_x;
         if (sweeps >= lim) begin
            code = STATUS_LIMIT;
            break;
         end
      end
      for (int i = 0; i < n; i++) begin
         r.status = code;
         r.sweeps = sweeps[15:0];
         r.index  = i[3:0];
         r.value  = next_x[i][31:0];
         r.last   = (i + 1 == n);
         pending_solns.push_back(r);
      end
   endfunction

   function automatic void predict_word(logic [31:0] v);
      int total;
      total = eff_unknowns() * (eff_unknowns() + 1);
      if (load_pos >= total) load_pos = 0;
      coef_mem[load_pos] = v;
      load_pos++;
      if (load_pos < total) return;
      load_pos = 0;
      solve_system();
   endfunction

   // result checker
   always @(posedge clock) begin
      soln_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[1:0];
         got.sweeps = rsp_tdata[17:2];
         got.index  = rsp_tdata[21:18];
         got.value  = rsp_tdata[53:22];
         got.last   = rsp_tlast;
         results_seen++;
         if (pending_solns.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: status %0d sweeps %0d index %0d value %h last %0d",
                        got.status, got.sweeps, got.index, got.value, got.last);
         end else begin
            want = pending_solns.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %0d %0d %h %0d / act %0d %0d %0d %h %0d",
                           want.status, want.sweeps, want.index, want.value, want.last,
                           got.status, got.sweeps, got.index, got.value, got.last);
            end
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_coef(input logic [31:0] v);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      predict_word(v);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_solns.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (addr)
         CSR_UNKNOWNS: begin
            mirror_unknowns = val[4:0];
            load_pos = 0;
         end
         CSR_TOLERANCE: mirror_tol = val;
         CSR_LIMIT:     mirror_limit = val;
         default: ;
      endcase
   endtask

   function automatic int rand_signed(int m);
      return int'($urandom_range(2 * m)) - m;
   endfunction

   // diagonally dominant system with random content
   task automatic send_dominant_system(input int m);
      int n;
      int row [MAX_UNKNOWNS + 1];
      longint sum;
      n = eff_unknowns();
      for (int i = 0; i < n; i++) begin
         sum = 0;
         for (int j = 0; j < n; j++) begin
            if (j != i) begin
               row[j] = rand_signed(m);
               sum += mag(longint'(row[j]));
            end
         end
         row[i] = int'(sum) + int'($urandom_range(1, m));
         if ($urandom_range(1)) row[i] = -row[i];
         row[n] = rand_signed(m * 4);
         for (int j = 0; j <= n; j++) send_coef(row[j]);
      end
   endtask

   task automatic send_noise_system();
      int n;
      n = eff_unknowns();
      for (int k = 0; k < n * (n + 1); k++) send_coef($urandom);
   endtask

   task automatic test_reset_defaults();
      send_dominant_system(1 << 18);
      wait_drained();
   endtask

   task automatic test_single_unknown();
      write_reg(CSR_UNKNOWNS, 16'd0);
      write_reg(CSR_TOLERANCE, 16'd0);
      write_reg(CSR_LIMIT, 16'hFFFF);
      send_coef(32'h0000_0001); send_coef(32'h7FFF_FFFF);
      send_coef(32'hFFFF_FFFF); send_coef(32'h8000_0000);
      send_coef(32'h8000_0000); send_coef(32'h8000_0000);
      send_coef(32'h0000_0000); send_coef(32'h0000_0005);
      send_coef(32'h0000_0003); send_coef(32'hFFFF_FFF9);
      wait_drained();
      write_reg(CSR_LIMIT, 16'd0);
      send_coef(32'h0002_0000); send_coef(32'h0005_0000);
      wait_drained();
   endtask

   task automatic test_error_cases();
      write_reg(CSR_UNKNOWNS, 16'd2);
      write_reg(CSR_LIMIT, 16'd20);
      write_reg(CSR_TOLERANCE, 16'd1);
      // row 0 fails dominance
      send_coef(32'h0001_0000); send_coef(32'h0002_0000); send_coef(32'h0001_0000);
      send_coef(32'h0000_0000); send_coef(32'h0004_0000); send_coef(32'h0001_0000);
      // all zero: passes dominance, zero diagonal
      repeat (6) send_coef(32'h0);
      wait_drained();
      // partial load, then a rewrite of unknowns restarts it
      send_coef(32'h1234_5678); send_coef(32'h8765_4321); send_coef(32'h0F0F_0F0F);
      wait_drained();
      write_reg(CSR_UNKNOWNS, 16'd2);
      send_dominant_system(1 << 16);
      wait_drained();
   endtask

   task automatic test_largest_system();
      write_reg(CSR_UNKNOWNS, 16'd31);
      write_reg(CSR_TOLERANCE, 16'hFFFF);
      write_reg(CSR_LIMIT, 16'd3);
      send_dominant_system(1 << 20);
      wait_drained();
   endtask

   task automatic random_settings();
      int pick;
      pick = $urandom_range(99);
      write_reg(CSR_UNKNOWNS, (pick < 85) ? 16'($urandom_range(1, 4)) :
                                            16'($urandom_range(5, 8)));
      pick = $urandom_range(99);
      write_reg(CSR_TOLERANCE, (pick < 20) ? 16'($urandom) : 16'($urandom_range(0, 64)));
      write_reg(CSR_LIMIT, (eff_unknowns() > 4) ? 16'($urandom_range(1, 8)) :
                                                   16'($urandom_range(1, 30)));
   endtask

   task automatic run_random_phase(input int idle, input int stall, input int words,
                                   input bit squeeze);
      int goal;
      idle_pct  = idle;
      stall_pct = stall;
      goal = words_sent + words;
      if (squeeze) begin
         write_reg(CSR_UNKNOWNS, 16'd2);
         write_reg(CSR_LIMIT, 16'd10);
         @(posedge clock);
         hold_left = 3000;
         repeat (3) send_dominant_system(1 << 18);
         wait_drained();
      end
      while (words_sent < goal) begin
         random_settings();
         if ($urandom_range(99) < 80) send_dominant_system(int'($urandom_range(1, 1 << 22)));
         else send_noise_system();
         wait_drained();
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, 20, 1'b1);
      run_random_phase(81, 0, 15, 1'b0);
      run_random_phase(0, 81, 15, 1'b0);
      run_random_phase(31, 31, 15, 1'b0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_single_unknown();
      test_error_cases();
      test_largest_system();
      test_random_traffic();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d coefficient words, %0d systems solved, %0d results checked",
               words_sent, systems_solved, results_seen);
      $display("sizes 1 to 16, error and saturation cases, four idling phases, %0d mismatches",
               mismatches);
      if (mismatches == 0 && pending_solns.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
